/* hdl/assert_macros.svh */
// Assertion macros shared by the palette color cycler RTL.
// Under SYNTHESIS every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PCC_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define PCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PCC_ASSERT(label, clk, rst, expr)
`define PCC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/pcc_pkg.sv */
// Package for the palette color cycler: command codes, payload layouts and
// the group check result type. No dependencies.
package pcc_pkg;

   localparam logic [1:0] CMD_WR_PAL = 2'd0;
   localparam logic [1:0] CMD_RD_PAL = 2'd1;
   localparam logic [1:0] CMD_WR_GRP = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [2:0]  pad;
      logic [15:0] phase_word;
      logic [15:0] last_offset;
      logic [15:0] first_offset;
      logic [15:0] run_count;
      logic [2:0]  group_index;
      logic [7:0]  palette_value;
      logic [9:0]  palette_index;
   } req_data_type;

   typedef struct packed {
      logic [5:0] pad;
      logic       changed;
      logic       status;
      logic [7:0] read_value;
   } rsp_data_type;

   typedef struct packed {
      logic enable;
      logic malformed;
   } grp_chk_type;

endpackage

/* hdl/pcc_grp_check.sv */
// Validity check for a color cycling group write.
// Depends on pcc_pkg for the check result type.
module pcc_grp_check #(
   parameter int PALETTE_BYTES = 768
) (
   input  logic [15:0]         run_count,
   input  logic [15:0]         first_offset,
   input  logic [15:0]         last_offset,
   output pcc_pkg::grp_chk_type chk
);

   // A value is a multiple of three when its base-4 digit sum is.
   function automatic logic mult3(input logic [15:0] v);
      logic [4:0] s1;
      logic [2:0] s2;
      logic [2:0] s3;
      s1 = '0;
      for (int i = 0; i < 8; i++) begin
         s1 = s1 + 5'(v[2*i +: 2]);
      end
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
      s3 = 3'(s2[1:0]) + 3'(s2[2]);
      return (s3 == 3'd0) || (s3 == 3'd3);
   endfunction

   logic [18:0] span_end;
   logic        range_ok;
   logic        span_ok;

   assign span_end = 19'(first_offset) + 19'({run_count, 1'b0}) + 19'(run_count);
   assign span_ok  = (span_end == 19'(last_offset));
   assign range_ok = (32'(last_offset) + 32'd3) <= 32'(PALETTE_BYTES);

   assign chk.enable    = (run_count != 16'd0);
   assign chk.malformed = chk.enable &&
                          !(mult3(first_offset) && mult3(last_offset) && range_ok && span_ok);

endmodule

/* hdl/palette_color_cycler_unit.sv */
// Top level of the palette color cycler: palette memory, group table and
// command sequencer. Depends on pcc_pkg, pcc_grp_check and assert_macros.svh.
//
// Each request transaction carries one command and returns exactly one response
// transaction. A palette byte write or a group write answers in the cycle after
// it is accepted, and an in-range palette byte read after the registered memory read.
// A tick visits the groups in order, one per cycle unless a group rotates; a
// group that rotates passes through S_HOLD, S_SHIFT and S_DRAIN before the next
// group is visited, and S_DONE answers the tick. The single write port of the
// palette memory moves one byte per cycle. One command is in flight at a time.
// The palette memory has no reset; the group table is cleared by reset.
`include "assert_macros.svh"

module palette_color_cycler_unit #(
   parameter int PALETTE_BYTES = 768,
   parameter int GROUP_COUNT   = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // palette_index, palette_value, group_index, run_count, first_offset,
   // last_offset, phase_word, zero padding
   input  logic [pcc_pkg::REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // read_value, status, changed, zero padding
   output logic [pcc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(PALETTE_BYTES);
   localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDATA = 3'd1;
   localparam logic [2:0] S_TGRP  = 3'd2;
   localparam logic [2:0] S_HOLD  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   pcc_pkg::req_data_type req;
   pcc_pkg::rsp_data_type rsp;
   pcc_pkg::grp_chk_type  chk;

   logic [7:0]    pal_mem [PALETTE_BYTES];
   logic [7:0]    pal_rd_ff;
   logic          mem_re;
   logic [AW-1:0] mem_ra;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [7:0]    mem_wd;

   logic          grp_act_ff   [GROUP_COUNT];
   logic [AW-1:0] grp_first_ff [GROUP_COUNT];
   logic [AW-1:0] grp_last_ff  [GROUP_COUNT];
   logic [7:0]    grp_int_ff   [GROUP_COUNT];
   logic [7:0]    grp_el_ff    [GROUP_COUNT];

   logic [2:0]    state_ff, state_in;
   logic [GW-1:0] grp_ff, grp_in;
   logic          any_ff, any_in;
   logic [1:0]    hk_ff, hk_in;
   logic [AW-1:0] a_ff, a_in;
   logic          pend_ff, pend_in;
   logic          pmem_ff, pmem_in;
   logic [AW-1:0] pa_ff, pa_in;
   logic [7:0]    held_ff [3];

   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]    rsp_rd_ff, rsp_rd_in;
   logic          rsp_st_ff, rsp_st_in;
   logic          rsp_ch_ff, rsp_ch_in;

   logic          req_accept;
   logic          idx_ok;
   logic          gi_ok;
   logic          grp_wr;
   logic          el_wr;
   logic [7:0]    el_val;
   logic [7:0]    el_next;
   logic [AW-1:0] cur_first;
   logic [AW-1:0] cur_last;
   logic [AW-1:0] a_diff;
   logic [AW-1:0] held_diff;
   logic          grp_is_last;

   assign req        = req_tdata;
   assign req_tready = (state_ff == S_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign idx_ok     = 32'(req.palette_index) < PALETTE_BYTES;
   assign gi_ok      = 32'(req.group_index) < GROUP_COUNT;

   assign cur_first   = grp_first_ff[grp_ff];
   assign cur_last    = grp_last_ff[grp_ff];
   assign el_next     = grp_el_ff[grp_ff] + 8'd1;
   assign a_diff      = a_ff - cur_first;
   assign held_diff   = pa_ff - cur_first;
   assign grp_is_last = (grp_ff == GW'(GROUP_COUNT - 1));

   pcc_grp_check #(
      .PALETTE_BYTES(PALETTE_BYTES)
   ) u_grp_check (
      .run_count   (req.run_count),
      .first_offset(req.first_offset),
      .last_offset (req.last_offset),
      .chk         (chk)
   );

   always_comb begin
      state_in      = state_ff;
      grp_in        = grp_ff;
      any_in        = any_ff;
      hk_in         = hk_ff;
      a_in          = a_ff;
      pend_in       = 1'b0;
      pmem_in       = pmem_ff;
      pa_in         = pa_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_rd_in     = rsp_rd_ff;
      rsp_st_in     = rsp_st_ff;
      rsp_ch_in     = rsp_ch_ff;
      mem_re        = 1'b0;
      mem_ra        = a_ff - AW'(3);
      mem_we        = pend_ff;
      mem_wa        = pa_ff;
      mem_wd        = pmem_ff ? pal_rd_ff : held_ff[held_diff[1:0]];
      grp_wr        = 1'b0;
      el_wr         = 1'b0;
      el_val        = 8'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_tuser)
                  pcc_pkg::CMD_WR_PAL: begin
                     mem_we        = idx_ok;
                     mem_wa        = AW'(req.palette_index);
                     mem_wd        = req.palette_value;
                     rsp_tvalid_in = 1'b1;
                     rsp_rd_in     = 8'd0;
                     rsp_st_in     = 1'b0;
                     rsp_ch_in     = 1'b0;
                  end
                  pcc_pkg::CMD_RD_PAL: begin
                     if (idx_ok) begin
                        mem_re   = 1'b1;
                        mem_ra   = AW'(req.palette_index);
                        state_in = S_RDATA;
                     end else begin
                        rsp_tvalid_in = 1'b1;
                        rsp_rd_in     = 8'd0;
                        rsp_st_in     = 1'b0;
                        rsp_ch_in     = 1'b0;
                     end
                  end
                  pcc_pkg::CMD_WR_GRP: begin
                     grp_wr        = gi_ok && !chk.malformed;
                     rsp_tvalid_in = 1'b1;
                     rsp_rd_in     = 8'd0;
                     rsp_st_in     = gi_ok && chk.malformed;
                     rsp_ch_in     = 1'b0;
                  end
                  pcc_pkg::CMD_TICK: begin
                     grp_in   = '0;
                     any_in   = 1'b0;
                     state_in = S_TGRP;
                  end
               endcase
            end
         end
         S_RDATA: begin
            rsp_tvalid_in = 1'b1;
            rsp_rd_in     = pal_rd_ff;
            rsp_st_in     = 1'b0;
            rsp_ch_in     = 1'b0;
            state_in      = S_IDLE;
         end
         S_TGRP: begin
            if (grp_act_ff[grp_ff] && (el_next >= grp_int_ff[grp_ff])) begin
               el_wr    = 1'b1;
               el_val   = 8'd0;
               any_in   = 1'b1;
               hk_in    = 2'd0;
               state_in = S_HOLD;
            end else begin
               el_wr  = grp_act_ff[grp_ff];
               el_val = el_next;
               if (grp_is_last) begin
                  state_in = S_DONE;
               end else begin
                  grp_in = grp_ff + GW'(1);
               end
            end
         end
         S_HOLD: begin
            hk_in = hk_ff + 2'd1;
            if (hk_ff == 2'd3) begin
               a_in     = cur_last + AW'(2);
               state_in = S_SHIFT;
            end else begin
               mem_re = 1'b1;
               mem_ra = cur_last + AW'(hk_ff);
            end
         end
         S_SHIFT: begin
            pend_in = 1'b1;
            pa_in   = a_ff;
            pmem_in = (a_diff >= AW'(3));
            mem_re  = (a_diff >= AW'(3));
            if (a_ff == cur_first) begin
               state_in = S_DRAIN;
            end else begin
               a_in = a_ff - AW'(1);
            end
         end
         S_DRAIN: begin
            if (grp_is_last) begin
               state_in = S_DONE;
            end else begin
               grp_in   = grp_ff + GW'(1);
               state_in = S_TGRP;
            end
         end
         S_DONE: begin
            rsp_tvalid_in = 1'b1;
            rsp_rd_in     = 8'd0;
            rsp_st_in     = 1'b0;
            rsp_ch_in     = any_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pal_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         pal_rd_ff <= pal_mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < GROUP_COUNT; g++) begin
            grp_act_ff[g]   <= 1'b0;
            grp_first_ff[g] <= '0;
            grp_last_ff[g]  <= '0;
            grp_int_ff[g]   <= 8'd0;
            grp_el_ff[g]    <= 8'd0;
         end
      end else begin
         for (int g = 0; g < GROUP_COUNT; g++) begin
            if (grp_wr && (int'(req.group_index) == g)) begin
               grp_act_ff[g]   <= chk.enable;
               grp_first_ff[g] <= AW'(req.first_offset);
               grp_last_ff[g]  <= AW'(req.last_offset);
               grp_int_ff[g]   <= req.phase_word[7:0];
               grp_el_ff[g]    <= req.phase_word[15:8];
            end else if (el_wr && (int'(grp_ff) == g)) begin
               grp_el_ff[g] <= el_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_HOLD) && (hk_ff != 2'd0)) begin
         held_ff[hk_ff - 2'd1] <= pal_rd_ff;
      end
      a_ff      <= a_in;
      pa_ff     <= pa_in;
      pmem_ff   <= pmem_in;
      hk_ff     <= hk_in;
      grp_ff    <= grp_in;
      any_ff    <= any_in;
      rsp_rd_ff <= rsp_rd_in;
      rsp_st_ff <= rsp_st_in;
      rsp_ch_ff <= rsp_ch_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp.pad        = '0;
   assign rsp.changed    = rsp_ch_ff;
   assign rsp.status     = rsp_st_ff;
   assign rsp.read_value = rsp_rd_ff;
   assign rsp_tdata      = rsp;
   assign rsp_tvalid     = rsp_tvalid_ff;

   `PCC_ASSERT(a_pend_in_rotation, clock, reset, !pend_ff || (state_ff == S_SHIFT) || (state_ff == S_DRAIN))
   `PCC_ASSERT_IMPLY(a_rotate_active_group, clock, reset, (state_ff == S_HOLD) || (state_ff == S_SHIFT), grp_act_ff[grp_ff])
   `PCC_ASSERT_IMPLY(a_rsp_slot_free, clock, reset, (state_ff == S_RDATA) || (state_ff == S_DONE), !rsp_tvalid_ff)
   `PCC_ASSERT_NEXT(a_read_waits_memory, clock, reset, req_accept && (req_tuser == pcc_pkg::CMD_RD_PAL) && idx_ok, (state_ff == S_RDATA) && !rsp_tvalid_ff)

endmodule

/* test/tb_palette_color_cycler_unit.sv */
// Self-checking testbench for palette_color_cycler_unit: directed and random commands
// on the request stream, each response checked against a predicted palette and group table.
// Depends on pcc_pkg and the palette_color_cycler_unit RTL.

class cycler_scoreboard;
   localparam int PAL_BYTES = 768;
   localparam int GROUPS    = 6;

   bit [7:0]              palette [PAL_BYTES];
   bit                    written [PAL_BYTES];
   bit [15:0]             grp_count [GROUPS];
   bit [15:0]             grp_first [GROUPS];
   bit [15:0]             grp_last [GROUPS];
   bit [7:0]              grp_interval [GROUPS];
   bit [7:0]              grp_elapsed [GROUPS];
   pcc_pkg::rsp_data_type pending_rsp [$];
   int                    errors;
   int                    reads;
   int                    group_writes;
   int                    rejected;
   int                    ticks;
   int                    changed_ticks;

   function void note_command(input logic [1:0] cmd, input pcc_pkg::req_data_type d);
      pcc_pkg::rsp_data_type want;
      bit [7:0]     held_byte [3];
      bit           held_seen [3];
      bit [7:0]     el;
      int           g, p, k, lo_byte, hi_byte, cnt;
      want = '0;
      case (cmd)
         pcc_pkg::CMD_WR_PAL: begin
            if (d.palette_index < PAL_BYTES) begin
               palette[d.palette_index] = d.palette_value;
               written[d.palette_index] = 1'b1;
            end
         end
         pcc_pkg::CMD_RD_PAL: begin
            reads++;
            if (d.palette_index < PAL_BYTES) want.read_value = palette[d.palette_index];
         end
         pcc_pkg::CMD_WR_GRP: begin
            cnt     = int'(d.run_count);
            lo_byte = int'(d.first_offset);
            hi_byte = int'(d.last_offset);
            if (d.group_index < GROUPS) begin
               group_writes++;
               if (cnt != 0 && (lo_byte % 3 != 0 || hi_byte % 3 != 0 ||
                                hi_byte + 3 > PAL_BYTES || lo_byte + 3 * cnt != hi_byte)) begin
                  want.status = 1'b1;
                  rejected++;
               end else begin
                  grp_count[d.group_index]    = d.run_count;
                  grp_first[d.group_index]    = d.first_offset;
                  grp_last[d.group_index]     = d.last_offset;
                  grp_interval[d.group_index] = d.phase_word[7:0];
                  grp_elapsed[d.group_index]  = d.phase_word[15:8];
               end
            end
         end
         default: begin
            ticks++;
            for (g = 0; g < GROUPS; g++) begin
               if (grp_count[g] != 0) begin
                  el = grp_elapsed[g] + 8'd1;
                  if (el < grp_interval[g]) begin
                     grp_elapsed[g] = el;
                  end else begin
                     grp_elapsed[g] = '0;
                     want.changed   = 1'b1;
                     lo_byte        = int'(grp_first[g]);
                     hi_byte        = int'(grp_last[g]);
                     if (hi_byte >= lo_byte && hi_byte + 3 <= PAL_BYTES) begin
                        for (k = 0; k < 3; k++) begin
                           held_byte[k] = palette[hi_byte + k];
                           held_seen[k] = written[hi_byte + k];
                        end
                        for (p = hi_byte; p > lo_byte; p -= 3) begin
                           for (k = 0; k < 3; k++) begin
                              palette[p + k] = palette[p - 3 + k];
                              written[p + k] = written[p - 3 + k];
                           end
                        end
                        for (k = 0; k < 3; k++) begin
                           palette[lo_byte + k] = held_byte[k];
                           written[lo_byte + k] = held_seen[k];
                        end
                     end
                  end
               end
            end
            if (want.changed) changed_ticks++;
         end
      endcase
      pending_rsp.insert(pending_rsp.size(), want);
   endfunction

   function void check_rsp(input pcc_pkg::rsp_data_type got);
      pcc_pkg::rsp_data_type want;
      if (pending_rsp.size() == 0) begin
         $display("%0t: response with none outstanding, expected nothing, actual %h",
                  $time, got);
         errors++;
         return;
      end
      want = pending_rsp.pop_front();
      if (got.read_value !== want.read_value) begin
         $display("%0t: read_value mismatch, expected %h, actual %h",
                  $time, want.read_value, got.read_value);
         errors++;
      end
      if (got.status !== want.status) begin
         $display("%0t: status mismatch, expected %b, actual %b",
                  $time, want.status, got.status);
         errors++;
      end
      if (got.changed !== want.changed) begin
         $display("%0t: changed mismatch, expected %b, actual %b",
                  $time, want.changed, got.changed);
         errors++;
      end
   endfunction

   function int readable_index();
      int start, n, idx;
      start = $urandom_range(PAL_BYTES - 1);
      for (n = 0; n < PAL_BYTES; n++) begin
         idx = (start + n) % PAL_BYTES;
         if (written[idx]) return idx;
      end
      return 1023;
   endfunction
endclass

module tb_palette_color_cycler_unit;

   localparam int STALL_LIMIT = 50000;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pcc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]                     req_tuser  = pcc_pkg::CMD_WR_PAL;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pcc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   cycler_scoreboard sb = new();
   int send_idle = 29;
   int recv_idle = 85;
   int stall_cycles = 0;

   palette_color_cycler_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready) sb.check_rsp(rsp_tdata);
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
      begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic pcc_pkg::req_data_type fresh_payload();
      logic [95:0]           bits;
      pcc_pkg::req_data_type d;
      bits  = {$urandom(), $urandom(), $urandom()};
      d     = bits[pcc_pkg::REQ_DATA_W-1:0];
      d.pad = '0;
      return d;
   endfunction

   task automatic send_command(input logic [1:0] cmd, input pcc_pkg::req_data_type d);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sb.note_command(cmd, d);
   endtask

   task automatic write_byte(input int idx, input int value);
      pcc_pkg::req_data_type d;
      d               = fresh_payload();
      d.palette_index = 10'(idx);
      d.palette_value = 8'(value);
      send_command(pcc_pkg::CMD_WR_PAL, d);
   endtask

   task automatic read_byte(input int idx);
      pcc_pkg::req_data_type d;
      d               = fresh_payload();
      d.palette_index = 10'(idx);
      send_command(pcc_pkg::CMD_RD_PAL, d);
   endtask

   task automatic write_group(input int gi, input int cnt, input int lo_byte,
                              input int hi_byte, input int phase);
      pcc_pkg::req_data_type d;
      d              = fresh_payload();
      d.group_index  = 3'(gi);
      d.run_count    = 16'(cnt);
      d.first_offset = 16'(lo_byte);
      d.last_offset  = 16'(hi_byte);
      d.phase_word   = 16'(phase);
      send_command(pcc_pkg::CMD_WR_GRP, d);
   endtask

   task automatic tick();
      send_command(pcc_pkg::CMD_TICK, fresh_payload());
   endtask

   task automatic random_command();
      int roll, cnt, t, interval, phase;
      roll = $urandom_range(99);
      if (roll < 30) begin
         if ($urandom_range(19) == 0) write_byte($urandom_range(1023, 768), $urandom_range(255));
         else if ($urandom_range(1)) write_byte($urandom_range(191), $urandom_range(255));
         else write_byte($urandom_range(767), $urandom_range(255));
      end else if (roll < 50) begin
         if ($urandom_range(19) == 0) read_byte($urandom_range(1023, 768));
         else read_byte(sb.readable_index());
      end else if (roll < 65) begin
         cnt = ($urandom_range(99) < 3) ? $urandom_range(255, 64) : $urandom_range(16, 1);
         if (cnt <= 63 && $urandom_range(9) < 7) t = $urandom_range(63 - cnt);
         else t = $urandom_range(255 - cnt);
         if (cnt > 64) interval = $urandom_range(255, 8);
         else if ($urandom_range(3) != 0) interval = $urandom_range(4);
         else interval = $urandom_range(255);
         phase = ($urandom_range(255) << 8) | interval;
         roll  = $urandom_range(99);
         if (roll < 65) begin
            write_group($urandom_range(5), cnt, 3 * t, 3 * (t + cnt), phase);
         end else if (roll < 75) begin
            write_group($urandom_range(7), 0, $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535));
         end else if (roll < 87) begin
            write_group($urandom_range(5), cnt, 3 * t,
                        3 * (t + cnt) + ($urandom_range(1) ? 3 : 1), phase);
         end else begin
            write_group($urandom_range(7), $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(65535), $urandom_range(65535));
         end
      end else begin
         tick();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_byte(0, 8'h00);
      write_byte(1, 8'hFF);
      write_byte(2, 8'h5A);
      write_byte(3, 8'hA5);
      write_byte(4, 8'h3C);
      write_byte(5, 8'hC3);
      write_byte(767, 8'hFF);
      write_byte(1023, 8'h77);
      read_byte(1023);
      read_byte(767);
      write_group(7, 1, 0, 3, 0);
      write_group(0, 1, 1, 4, 0);
      write_group(0, 1, 765, 768, 0);
      write_group(1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      write_group(2, 0, 16'hFFFF, 12345, 16'hFFFF);
      tick();
      write_group(0, 1, 0, 3, 16'h0000);
      tick();
      read_byte(0);
      // Elapsed starts at 255 so the first tick wraps it to zero without a rotation.
      write_group(5, 255, 0, 765, 16'hFF02);
      tick();
      tick();
      tick();
      write_group(0, 0, 0, 0, 0);
      write_group(5, 0, 0, 0, 0);
      read_byte(sb.readable_index());

      repeat (185) random_command();
      send_idle = 85;
      recv_idle = 29;
      repeat (185) random_command();
      send_idle = 0;
      recv_idle = 0;
      repeat (185) random_command();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Ran %0d reads, %0d group writes (%0d rejected) and %0d ticks,",
               sb.reads, sb.group_writes, sb.rejected, sb.ticks);
      $display("%0d of the ticks rotating at least one group.", sb.changed_ticks);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
